/* rtl/core/itt_pkg.sv */
// itt_pkg: shared types and codes of the three-channel interval timer
// no dependencies; used by itt_channel and interval_timer_three_channels
`timescale 1ns / 1ps
`default_nettype none

package itt_pkg;

    localparam int CHANNELS = 3;
    localparam int NCH_MAX  = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] PORT_CTRL  = 2'd3;
    localparam logic [1:0] ACC_LATCH  = 2'b00;
    localparam logic [1:0] MODE_SQUARE = 2'b11;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] port;
        logic [7:0] wdata;
    } t_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic [2:0] out_levels;
    } t_out;

    typedef struct packed {
        logic       tick;
        logic       ctrl_wr;
        logic       data_wr;
        logic       data_rd;
        logic [7:0] wdata;
    } t_chan_cmd;

endpackage

`default_nettype wire

/* rtl/core/itt_channel.sv */
// itt_channel: one 16-bit down counter with reload, count latch and output pin
// depends on itt_pkg
`timescale 1ns / 1ps
`default_nettype none

module itt_channel (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire itt_pkg::t_chan_cmd i_cmd,
    output logic [7:0]              o_rdata,
    output logic                    o_out_level
);

    logic [15:0] r_counter, n_counter;
    logic [15:0] r_reload, n_reload;
    logic [15:0] r_latched, n_latched;
    logic        r_square, n_square;
    logic        r_out, n_out;
    logic        r_latch_valid, n_latch_valid;
    logic        r_write_high, n_write_high;
    logic        r_read_high, n_read_high;
    logic        r_load_pending, n_load_pending;
    logic        r_running, n_running;

    logic [16:0] w_v;
    logic [16:0] w_dec;
    logic [15:0] w_rd_src;
    logic [15:0] w_cnt_m1;

    always_comb begin
        n_counter      = r_counter;
        n_reload       = r_reload;
        n_latched      = r_latched;
        n_square       = r_square;
        n_out          = r_out;
        n_latch_valid  = r_latch_valid;
        n_write_high   = r_write_high;
        n_read_high    = r_read_high;
        n_load_pending = r_load_pending;
        n_running      = r_running;
        o_rdata        = 8'd0;

        w_v      = (r_counter == 16'd0) ? 17'h10000 : {1'b0, r_counter};
        w_dec    = w_v[0] ? (r_out ? 17'd1 : 17'd3) : 17'd2;
        w_rd_src = r_latch_valid ? r_latched : r_counter;
        w_cnt_m1 = r_counter - 16'd1;

        priority if (i_cmd.tick) begin
            if (r_load_pending && (!r_running || !r_square)) begin
                n_counter      = r_reload;
                n_load_pending = 1'b0;
                n_running      = 1'b1;
            end else if (r_running) begin
                if (!r_square) begin
                    n_counter = w_cnt_m1;
                    if (w_cnt_m1 == 16'd0) begin
                        n_out = 1'b1;
                    end
                end else if (w_v <= w_dec) begin
                    n_out          = ~r_out;
                    n_load_pending = 1'b0;
                    n_counter      = r_reload;
                end else begin
                    n_counter = 16'(w_v - w_dec);
                end
            end
        end else if (i_cmd.ctrl_wr) begin
            if (i_cmd.wdata[5:4] == itt_pkg::ACC_LATCH) begin
                if (!r_latch_valid) begin
                    n_latched     = r_counter;
                    n_latch_valid = 1'b1;
                end
            end else begin
                n_square       = (i_cmd.wdata[2:1] == itt_pkg::MODE_SQUARE);
                n_out          = n_square;
                n_latch_valid  = 1'b0;
                n_write_high   = 1'b0;
                n_read_high    = 1'b0;
                n_load_pending = 1'b0;
                n_running      = 1'b0;
            end
        end else if (i_cmd.data_wr) begin
            if (!r_write_high) begin
                n_reload     = {r_reload[15:8], i_cmd.wdata};
                n_write_high = 1'b1;
                if (!r_square) begin
                    n_running      = 1'b0;
                    n_load_pending = 1'b0;
                    n_out          = 1'b0;
                end
            end else begin
                n_reload       = {i_cmd.wdata, r_reload[7:0]};
                n_write_high   = 1'b0;
                n_load_pending = 1'b1;
                if (!r_square) begin
                    n_out = 1'b0;
                end
            end
        end else if (i_cmd.data_rd) begin
            if (r_read_high) begin
                o_rdata       = w_rd_src[15:8];
                n_read_high   = 1'b0;
                n_latch_valid = 1'b0;
            end else begin
                o_rdata     = w_rd_src[7:0];
                n_read_high = 1'b1;
            end
        end else begin
            o_rdata = 8'd0;
        end
    end

    assign o_out_level = n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter      <= '0;
            r_reload       <= '0;
            r_latched      <= '0;
            r_square       <= 1'b0;
            r_out          <= 1'b0;
            r_latch_valid  <= 1'b0;
            r_write_high   <= 1'b0;
            r_read_high    <= 1'b0;
            r_load_pending <= 1'b0;
            r_running      <= 1'b0;
        end else begin
            r_counter      <= n_counter;
            r_reload       <= n_reload;
            r_latched      <= n_latched;
            r_square       <= n_square;
            r_out          <= n_out;
            r_latch_valid  <= n_latch_valid;
            r_write_high   <= n_write_high;
            r_read_high    <= n_read_high;
            r_load_pending <= n_load_pending;
            r_running      <= n_running;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/interval_timer_three_channels.sv */
// interval_timer_three_channels: top level, input register, channel decode, result register
// depends on itt_pkg and itt_channel
// an accepted transaction passes from the input register to the result register
// throughput: one transaction per cycle unless stalled; channel state updates in one pass
// a stalled result register holds the input register, which then drops o_ready
// reset: synchronous active-low i_rst_n clears all counters, latches and valids
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_three_channels (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire itt_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output itt_pkg::t_out      o_data
);

    logic          r_in_valid;
    itt_pkg::t_in  r_in;
    logic          r_out_valid;
    itt_pkg::t_out r_out;
    logic          w_advance;
    logic          w_accept;
    logic [7:0]    w_rd [itt_pkg::NCH_MAX];
    logic [2:0]    w_levels;
    logic [7:0]    w_rdata;

    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_accept  = i_valid && o_ready;

    for (genvar c = 0; c < itt_pkg::NCH_MAX; c++) begin : g_ch
        localparam logic [1:0] CH_ID = 2'(c);
        if (c < itt_pkg::CHANNELS) begin : g_on
            itt_pkg::t_chan_cmd w_cmd;
            always_comb begin
                w_cmd.tick    = w_advance && (r_in.op == itt_pkg::OP_TICK);
                w_cmd.ctrl_wr = w_advance && (r_in.op == itt_pkg::OP_WRITE)
                                && (r_in.port == itt_pkg::PORT_CTRL)
                                && (r_in.wdata[7:6] == CH_ID);
                w_cmd.data_wr = w_advance && (r_in.op == itt_pkg::OP_WRITE)
                                && (r_in.port == CH_ID);
                w_cmd.data_rd = w_advance && (r_in.op == itt_pkg::OP_READ)
                                && (r_in.port == CH_ID);
                w_cmd.wdata   = r_in.wdata;
            end
            itt_channel u_channel (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .o_rdata     (w_rd[c]),
                .o_out_level (w_levels[c])
            );
        end else begin : g_off
            assign w_rd[c]     = 8'd0;
            assign w_levels[c] = 1'b0;
        end
    end

    always_comb begin
        w_rdata = 8'd0;
        for (int c = 0; c < itt_pkg::NCH_MAX; c++) begin
            w_rdata = w_rdata | w_rd[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_data;
        end
        if (w_advance) begin
            r_out.rdata      <= w_rdata;
            r_out.out_levels <= w_levels;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // a held transaction is never dropped while the result side stalls
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid)
        else $error("input transaction lost");

    // every processed transaction produces a result
    a_out_made: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result not produced");

    // only a read returns a nonzero byte
    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_in.op != itt_pkg::OP_READ) |=> (r_out.rdata == 8'd0))
        else $error("nonzero rdata on non-read");

endmodule

`default_nettype wire
